// ----- src/ssp_pkg.sv -----
// Shared types, constants and helpers for the servo sweep/poll controller.
package ssp_pkg;

    // Controller constants
    localparam int unsigned FEEDBACK_TIMEOUT_TICKS = 100;
    localparam int unsigned TIMER_BITS             = 16;
    localparam int unsigned CMP_BITS               = 32;

    // Field widths
    localparam int unsigned POS_BITS   = 10;
    localparam int unsigned ID_BITS    = 8;
    localparam int unsigned ERR_BITS   = 8;
    localparam int unsigned CNT_BITS   = 16;
    localparam int unsigned PER_BITS   = 16;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ID       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_POS  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_POS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_PER = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACK_TO   = 3'd7;

    // Reset values of the configuration registers
    localparam logic [POS_BITS-1:0] RST_MAX_POS  = 10'd1023;
    localparam logic [POS_BITS-1:0] RST_SPEED    = 10'd512;
    localparam logic [POS_BITS-1:0] RST_MARGIN   = 10'd20;
    localparam logic [PER_BITS-1:0] RST_POLL_PER = 16'd100;
    localparam logic [PER_BITS-1:0] RST_ACK_TO   = 16'd100;

    // Reported phase codes
    localparam logic [1:0] PHC_IDLE   = 2'd0;
    localparam logic [1:0] PHC_ACK    = 2'd1;
    localparam logic [1:0] PHC_MOVING = 2'd2;
    localparam logic [1:0] PHC_POLL   = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_REPLY_ERR = 2'd1;
    localparam logic [1:0] EV_ACK_TO    = 2'd2;
    localparam logic [1:0] EV_FB_TO     = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_ACK    = 4'b0010,
        PH_MOVING = 4'b0100,
        PH_POLL   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                operating_mode;
        logic [ID_BITS-1:0]  servo_id;
        logic [POS_BITS-1:0] min_position;
        logic [POS_BITS-1:0] max_position;
        logic [POS_BITS-1:0] move_speed;
        logic [POS_BITS-1:0] reverse_margin;
        logic [PER_BITS-1:0] poll_period;
        logic [PER_BITS-1:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic                reply_valid;
        logic [ERR_BITS-1:0] reply_error;
        logic [POS_BITS-1:0] reply_position;
        logic                reset_request;
    } item_t;

    typedef struct packed {
        logic                cmd_valid;
        logic                cmd_is_read;
        logic [ID_BITS-1:0]  cmd_target_id;
        logic [POS_BITS-1:0] cmd_goal;
        logic [POS_BITS-1:0] cmd_speed;
        logic                feedback_valid;
        logic [POS_BITS-1:0] feedback_position;
        logic [CNT_BITS-1:0] feedback_count;
        logic [1:0]          controller_phase;
        logic [1:0]          event_status;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:   code = PHC_IDLE;
            PH_ACK:    code = PHC_ACK;
            PH_MOVING: code = PHC_MOVING;
            PH_POLL:   code = PHC_POLL;
            default:   code = PHC_IDLE;
        endcase
        return code;
    endfunction

    // Saturating +1
    function automatic logic [TIMER_BITS-1:0] timer_advance(input logic [TIMER_BITS-1:0] t);
        return (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
    endfunction

endpackage

// ----- src/servo_sweep_poll_controller_core.sv -----
// Top level of the servo sweep/poll controller: input stage, controller, result register.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  in       | sink      | in_valid / in_stall    | reply_valid, reply_error,
//           |           |                        | reply_position, reset_request
//  out      | source    | out_valid / out_stall  | cmd_*, feedback_*, controller_phase,
//           |           |                        | event_status
//  cfg      | sink      | cfg_write              | cfg_index, cfg_data
//
// One request per clock sustained while the result is not stalled. A request is
// held in the input register, the controller logic runs between that register
// and the result register, from which its result is offered.
// Reset (rst_n, async active low) returns the controller to idle, sweep up,
// counters and timers clear, configuration to its defaults.
// A stalled result holds in the result register; the input register still
// takes one more request, after which in_stall follows out_stall.
module servo_sweep_poll_controller_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_write,
    input  logic [ssp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ssp_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                reply_valid,
    input  logic [ssp_pkg::ERR_BITS-1:0]        reply_error,
    input  logic [ssp_pkg::POS_BITS-1:0]        reply_position,
    input  logic                                reset_request,

    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                cmd_valid,
    output logic                                cmd_is_read,
    output logic [ssp_pkg::ID_BITS-1:0]         cmd_target_id,
    output logic [ssp_pkg::POS_BITS-1:0]        cmd_goal,
    output logic [ssp_pkg::POS_BITS-1:0]        cmd_speed,
    output logic                                feedback_valid,
    output logic [ssp_pkg::POS_BITS-1:0]        feedback_position,
    output logic [ssp_pkg::CNT_BITS-1:0]        feedback_count,
    output logic [1:0]                          controller_phase,
    output logic [1:0]                          event_status
);

    ssp_pkg::cfg_t      cfg;
    ssp_pkg::item_t     in_item;
    ssp_pkg::result_t   step_res;

    // input stage
    logic               s1_valid_reg, s1_valid_next;
    ssp_pkg::item_t     s1_item_reg;

    // result stage
    logic               out_valid_reg, out_valid_next;
    ssp_pkg::result_t   out_res_reg;

    logic               out_free;   // result register can take a new result
    logic               advance;    // input stage moves through the controller
    logic               in_take;    // request accepted this edge

    assign in_item.reply_valid    = reply_valid;
    assign in_item.reply_error    = reply_error;
    assign in_item.reply_position = reply_position;
    assign in_item.reset_request  = reset_request;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    ssp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssp_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
        if (advance)
            out_res_reg <= step_res;
    end

    assign out_valid         = out_valid_reg;
    assign cmd_valid         = out_res_reg.cmd_valid;
    assign cmd_is_read       = out_res_reg.cmd_is_read;
    assign cmd_target_id     = out_res_reg.cmd_target_id;
    assign cmd_goal          = out_res_reg.cmd_goal;
    assign cmd_speed         = out_res_reg.cmd_speed;
    assign feedback_valid    = out_res_reg.feedback_valid;
    assign feedback_position = out_res_reg.feedback_position;
    assign feedback_count    = out_res_reg.feedback_count;
    assign controller_phase  = out_res_reg.controller_phase;
    assign event_status      = out_res_reg.event_status;

    // a position read always leaves the controller awaiting position
    a_read_to_poll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_valid && cmd_is_read |-> controller_phase == ssp_pkg::PHC_POLL)
        else $error("read command without awaiting-position phase");

    // a goal write never carries zero speed
    a_write_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_valid && !cmd_is_read |-> cmd_speed != '0)
        else $error("goal write with zero speed");

    // accepted feedback comes with no event and no command
    a_fb_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && feedback_valid |-> event_status == ssp_pkg::EV_NONE && !cmd_valid)
        else $error("feedback mixed with event or command");

    // a stall on the input side only arises from a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid)
        else $error("input stalled without a pending result");

endmodule

// ----- src/ssp_cfg_regs.sv -----
// Configuration register file of the servo sweep/poll controller.
module ssp_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ssp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ssp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ssp_pkg::cfg_t                       cfg
);

    ssp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operating_mode <= 1'b0;
            cfg_reg.servo_id       <= '0;
            cfg_reg.min_position   <= '0;
            cfg_reg.max_position   <= ssp_pkg::RST_MAX_POS;
            cfg_reg.move_speed     <= ssp_pkg::RST_SPEED;
            cfg_reg.reverse_margin <= ssp_pkg::RST_MARGIN;
            cfg_reg.poll_period    <= ssp_pkg::RST_POLL_PER;
            cfg_reg.ack_timeout    <= ssp_pkg::RST_ACK_TO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssp_pkg::CFG_MODE:     cfg_reg.operating_mode <= cfg_data[0];
                ssp_pkg::CFG_ID:       cfg_reg.servo_id <= cfg_data[ssp_pkg::ID_BITS-1:0];
                ssp_pkg::CFG_MIN_POS:  cfg_reg.min_position <= cfg_data[ssp_pkg::POS_BITS-1:0];
                ssp_pkg::CFG_MAX_POS:  cfg_reg.max_position <= cfg_data[ssp_pkg::POS_BITS-1:0];
                ssp_pkg::CFG_SPEED:    cfg_reg.move_speed <= cfg_data[ssp_pkg::POS_BITS-1:0];
                ssp_pkg::CFG_MARGIN:   cfg_reg.reverse_margin <= cfg_data[ssp_pkg::POS_BITS-1:0];
                ssp_pkg::CFG_POLL_PER: cfg_reg.poll_period <= cfg_data[ssp_pkg::PER_BITS-1:0];
                ssp_pkg::CFG_ACK_TO:   cfg_reg.ack_timeout <= cfg_data[ssp_pkg::PER_BITS-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/ssp_ctrl.sv -----
// Controller state and per-tick next-state / result logic.
module ssp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ssp_pkg::item_t    item,
    input  ssp_pkg::cfg_t     cfg,
    output ssp_pkg::result_t  result
);

    ssp_pkg::phase_t                    phase_reg, phase_next;
    logic                               sweep_up_reg, sweep_up_next;
    logic                               reset_pending_reg, reset_pending_next;
    logic [ssp_pkg::POS_BITS-1:0]       target_reg, target_next;
    logic [ssp_pkg::POS_BITS-1:0]       last_pos_reg, last_pos_next;
    logic [ssp_pkg::CNT_BITS-1:0]       count_reg, count_next;
    logic [ssp_pkg::TIMER_BITS-1:0]     reply_timer_reg, reply_timer_next;
    logic [ssp_pkg::TIMER_BITS-1:0]     poll_timer_reg, poll_timer_next;

    logic [ssp_pkg::TIMER_BITS-1:0]     rt_adv, pt_adv;
    logic                               ack_expired, fb_expired, poll_due;
    logic                               near_top, near_bottom;
    ssp_pkg::result_t                   res;

    always_comb
    begin
        rt_adv      = ssp_pkg::timer_advance(reply_timer_reg);
        pt_adv      = ssp_pkg::timer_advance(poll_timer_reg);
        ack_expired = ssp_pkg::CMP_BITS'(rt_adv) > ssp_pkg::CMP_BITS'(cfg.ack_timeout);
        fb_expired  = ssp_pkg::CMP_BITS'(rt_adv) >
                      ssp_pkg::CMP_BITS'(ssp_pkg::FEEDBACK_TIMEOUT_TICKS);
        poll_due    = ssp_pkg::CMP_BITS'(pt_adv) > ssp_pkg::CMP_BITS'(cfg.poll_period);
        // p > t - m  <=>  p + m > t ; p < t + m, all without wrap
        near_top    = ({1'b0, item.reply_position} + {1'b0, cfg.reverse_margin}) >
                      {1'b0, target_reg};
        near_bottom = {1'b0, item.reply_position} <
                      ({1'b0, target_reg} + {1'b0, cfg.reverse_margin});

        phase_next         = phase_reg;
        sweep_up_next      = sweep_up_reg;
        reset_pending_next = reset_pending_reg | item.reset_request;
        target_next        = target_reg;
        last_pos_next      = last_pos_reg;
        count_next         = count_reg;
        reply_timer_next   = rt_adv;
        poll_timer_next    = pt_adv;

        res                = '0;
        res.event_status   = ssp_pkg::EV_NONE;

        case (phase_reg)
            ssp_pkg::PH_IDLE:
            begin
                reset_pending_next = 1'b0;
                if (cfg.operating_mode && sweep_up_reg)
                    target_next = cfg.max_position;
                else
                    target_next = cfg.min_position;
                res.cmd_valid     = 1'b1;
                res.cmd_target_id = cfg.servo_id;
                res.cmd_goal      = target_next;
                res.cmd_speed     = (cfg.move_speed == '0) ?
                                    ssp_pkg::POS_BITS'(1) : cfg.move_speed;
                reply_timer_next  = '0;
                phase_next        = ssp_pkg::PH_ACK;
            end
            ssp_pkg::PH_ACK:
            begin
                if (item.reply_valid)
                begin
                    if (item.reply_error != '0)
                    begin
                        res.event_status = ssp_pkg::EV_REPLY_ERR;
                        phase_next       = ssp_pkg::PH_IDLE;
                    end
                    else if (reset_pending_next)
                        phase_next = ssp_pkg::PH_IDLE;
                    else
                        phase_next = ssp_pkg::PH_MOVING;
                end
                else if (ack_expired)
                begin
                    res.event_status = ssp_pkg::EV_ACK_TO;
                    phase_next       = ssp_pkg::PH_IDLE;
                end
            end
            ssp_pkg::PH_MOVING:
            begin
                if (poll_due)
                begin
                    res.cmd_valid     = 1'b1;
                    res.cmd_is_read   = 1'b1;
                    res.cmd_target_id = cfg.servo_id;
                    poll_timer_next   = '0;
                    reply_timer_next  = '0;
                    phase_next        = ssp_pkg::PH_POLL;
                end
                else if (reset_pending_next)
                    phase_next = ssp_pkg::PH_IDLE;
            end
            ssp_pkg::PH_POLL:
            begin
                if (item.reply_valid)
                begin
                    if (item.reply_error != '0)
                    begin
                        res.event_status = ssp_pkg::EV_REPLY_ERR;
                        if (!cfg.operating_mode)
                            phase_next = ssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        last_pos_next      = item.reply_position;
                        count_next         = count_reg + 1'b1;
                        res.feedback_valid = 1'b1;
                        if (!cfg.operating_mode)
                            phase_next = ssp_pkg::PH_MOVING;
                        else if (sweep_up_reg && near_top)
                        begin
                            phase_next    = ssp_pkg::PH_IDLE;
                            sweep_up_next = 1'b0;
                        end
                        else if (!sweep_up_reg && near_bottom)
                        begin
                            phase_next    = ssp_pkg::PH_IDLE;
                            sweep_up_next = 1'b1;
                        end
                        else
                            phase_next = ssp_pkg::PH_MOVING;
                    end
                end
                else if (fb_expired)
                begin
                    res.event_status = ssp_pkg::EV_FB_TO;
                    phase_next = reset_pending_next ? ssp_pkg::PH_IDLE : ssp_pkg::PH_MOVING;
                end
            end
            default:
            begin
                phase_next = ssp_pkg::PH_IDLE;
            end
        endcase

        res.feedback_position = last_pos_next;
        res.feedback_count    = count_next;
        res.controller_phase  = ssp_pkg::phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ssp_pkg::PH_IDLE;
            sweep_up_reg      <= 1'b1;
            reset_pending_reg <= 1'b0;
            target_reg        <= '0;
            last_pos_reg      <= '0;
            count_reg         <= '0;
            reply_timer_reg   <= '0;
            poll_timer_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            sweep_up_reg      <= sweep_up_next;
            reset_pending_reg <= reset_pending_next;
            target_reg        <= target_next;
            last_pos_reg      <= last_pos_next;
            count_reg         <= count_next;
            reply_timer_reg   <= reply_timer_next;
            poll_timer_reg    <= poll_timer_next;
        end
    end

    assign result = res;

endmodule
